// ----- rtl/utd_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder package
// Shared types and constants: byte classes, masks, queue depth, state, results.
// ----------------------------------------------------------------------------
package utd_pkg;

	// Byte class boundaries and payload masks of UTF-8.
	localparam logic [7:0] CONT_MIN   = 8'h80;
	localparam logic [7:0] LEAD2_MIN  = 8'hC0;
	localparam logic [7:0] LEAD3_MIN  = 8'hE0;
	localparam logic [7:0] LEAD4_MIN  = 8'hF0;
	localparam logic [7:0] INVAL_MIN  = 8'hF8;
	localparam logic [7:0] LEAD2_MASK = 8'h1F;
	localparam logic [7:0] LEAD3_MASK = 8'h0F;
	localparam logic [7:0] LEAD4_MASK = 8'h07;
	localparam logic [7:0] CONT_MASK  = 8'h3F;
	localparam logic [7:0] END_BYTE   = 8'h00;

	// Result queue depth; two slots must be free to retire one byte.
	localparam int unsigned RQ_DEPTH = 4;
	localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);

	// Running decoder state.
	typedef struct packed {
		logic [15:0] partial_point;
		logic [1:0]  bytes_expected;
		logic [5:0]  chars_out;
		logic        string_done;
	} utd_state_t;

	// One result item.
	typedef struct packed {
		logic [15:0] code_unit;
		logic [5:0]  char_index;
		logic        is_end;
	} utd_result_t;

	// Results caused by one byte: a character and/or an end item.
	typedef struct packed {
		logic        first_valid;
		utd_result_t first;
		logic        second_valid;
		utd_result_t second;
	} utd_step_t;

endpackage

// ----- rtl/utd_byte_if.sv -----
// ----------------------------------------------------------------------------
// UTF-8 byte channel
// Valid/ready channel that carries one string byte per item.
// ----------------------------------------------------------------------------
interface utd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       new_string;

	modport source (output valid, output in_byte, output new_string, input ready);
	modport sink   (input valid, input in_byte, input new_string, output ready);
endinterface

// ----- rtl/utd_char_if.sv -----
// ----------------------------------------------------------------------------
// UCS-2 character channel
// Valid/ready channel that carries one decoded character or end item.
// ----------------------------------------------------------------------------
interface utd_char_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic [5:0]  char_index;
	logic        is_end;

	modport source (output valid, output code_unit, output char_index, output is_end,
		input ready);
	modport sink   (input valid, input code_unit, input char_index, input is_end,
		output ready);
endinterface

// ----- rtl/utd_decode.sv -----
// ----------------------------------------------------------------------------
// UTF-8 byte decode step
// Next-state and result logic for one byte against the running decoder state.
// ----------------------------------------------------------------------------
module utd_decode
	import utd_pkg::*;
#(
	parameter int unsigned MAX_CHARS = 60
) (
	input  utd_state_t state,
	input  logic [7:0] in_byte,
	input  logic       new_string,
	output utd_state_t next_state,
	output utd_step_t  step
);

	utd_state_t  st;
	logic        give;
	logic [1:0]  exp_dec;
	logic [15:0] shifted;
	logic [5:0]  chars_inc;

	always_comb begin
		st        = new_string ? '0 : state;
		exp_dec   = st.bytes_expected - 2'd1;
		shifted   = {st.partial_point[9:0], in_byte[5:0] & CONT_MASK[5:0]};
		give      = 1'b0;
		next_state = st;
		step      = '0;

		if (!st.string_done) begin
			if (in_byte == END_BYTE) begin
				step.first_valid = 1'b1;
				step.first = '{code_unit: 16'd0, char_index: st.chars_out, is_end: 1'b1};
				next_state.string_done = 1'b1;
			end else if (in_byte >= LEAD2_MIN) begin
				// Lead bytes load their payload; bytes beyond four-byte leads are dropped.
				if (in_byte < LEAD3_MIN) begin
					next_state.bytes_expected = 2'd1;
					next_state.partial_point  = {8'd0, in_byte & LEAD2_MASK};
				end else if (in_byte < LEAD4_MIN) begin
					next_state.bytes_expected = 2'd2;
					next_state.partial_point  = {8'd0, in_byte & LEAD3_MASK};
				end else if (in_byte < INVAL_MIN) begin
					next_state.bytes_expected = 2'd3;
					next_state.partial_point  = {8'd0, in_byte & LEAD4_MASK};
				end
			end else if (in_byte >= CONT_MIN) begin
				if (st.bytes_expected != 2'd0) begin
					next_state.bytes_expected = exp_dec;
					next_state.partial_point  = shifted;
					give = (exp_dec == 2'd0);
				end else begin
					// A stray continuation repeats the held value.
					give = 1'b1;
				end
			end else begin
				// ASCII replaces the held value but leaves a pending count alone.
				next_state.partial_point = {8'd0, in_byte};
				give = 1'b1;
			end

			if (give) begin
				chars_inc = st.chars_out + 6'd1;
				step.first_valid = 1'b1;
				step.first = '{code_unit: next_state.partial_point,
					char_index: st.chars_out, is_end: 1'b0};
				next_state.chars_out = chars_inc;
				if (chars_inc >= 6'(MAX_CHARS)) begin
					step.second_valid = 1'b1;
					step.second = '{code_unit: 16'd0, char_index: chars_inc, is_end: 1'b1};
					next_state.string_done = 1'b1;
				end
			end else begin
				chars_inc = st.chars_out;
			end
		end else begin
			chars_inc = st.chars_out;
		end
	end

endmodule

// ----- rtl/utf8_to_ucs2_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder unit
// Decodes a zero-terminated UTF-8 byte stream into 16-bit characters.
// ----------------------------------------------------------------------------
// Path: an accepted byte waits in the input stage, then its results enter the queue.
// Throughput: one byte per cycle while the queue has two free slots; a byte that
// ends the string on the character limit makes two results, which drain one per
// cycle from the result queue. Reset: arst_n clears the decoder state, the input
// stage and the result queue at once; bytes are taken as soon as reset is released.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_unit
	import utd_pkg::*;
#(
	parameter int unsigned MAX_CHARS = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	utd_byte_if.sink    byte_ch,
	utd_char_if.source  char_ch
);

	// Input stage: the accepted byte waits here until it is decoded and retired.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       new_s1;

	// Running decoder state and the decode step for the byte in the input stage.
	utd_state_t state_q;
	utd_state_t state_next;
	utd_step_t  step;

	// Result queue, kept in flops: up to two writes and one read per cycle.
	utd_result_t             rq_mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0]        wr_ptr_q;
	logic [RQ_AW-1:0]        rd_ptr_q;
	logic [RQ_AW:0]          count_q;
	logic                    advance;
	logic                    pop;
	logic [1:0]              push_n;

	utd_decode #(.MAX_CHARS(MAX_CHARS)) u_decode (
		.state      (state_q),
		.in_byte    (byte_s1),
		.new_string (new_s1),
		.next_state (state_next),
		.step       (step)
	);

	// The input stage retires its byte once two queue slots are free, which
	// covers the worst case of a character followed by an end item. With a
	// depth of four the queue never blocks a steady one-result-per-cycle flow.
	assign advance      = valid_s1 && (count_q <= (RQ_AW+1)'(RQ_DEPTH - 2));
	assign byte_ch.ready = !valid_s1 || advance;
	assign pop          = char_ch.valid && char_ch.ready;
	assign push_n       = advance ? ({1'b0, step.first_valid} + {1'b0, step.second_valid})
		: 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			byte_s1 <= byte_ch.in_byte;
			new_s1  <= byte_ch.new_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// The second result only ever follows a first one, so it goes one slot on.
	always_ff @(posedge clk) begin
		if (advance && step.first_valid) begin
			rq_mem_q[wr_ptr_q] <= step.first;
		end
		if (advance && step.second_valid) begin
			rq_mem_q[wr_ptr_q + RQ_AW'(1)] <= step.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_AW'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RQ_AW'(1);
			end
			count_q <= count_q + (RQ_AW+1)'(push_n) - (RQ_AW+1)'(pop);
		end
	end

	assign char_ch.valid      = (count_q != '0);
	assign char_ch.code_unit  = rq_mem_q[rd_ptr_q].code_unit;
	assign char_ch.char_index = rq_mem_q[rd_ptr_q].char_index;
	assign char_ch.is_end     = rq_mem_q[rd_ptr_q].is_end;

endmodule

// ----- rtl/utd_checker.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UCS-2 decoder checker
// Port-level assertions on the decoder unit, attached by bind.
// ----------------------------------------------------------------------------
module utd_checker #(
	parameter int unsigned MAX_CHARS = 60
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] code_unit,
	input logic [5:0]  char_index,
	input logic        is_end
);

	// A result that is offered stays offered until it is taken.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item withdrawn before it was taken");

	// A stalled result keeps its payload.
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(code_unit) && $stable(char_index)
			&& $stable(is_end))
		else $error("result payload changed while stalled");

	// End items always carry a zero character.
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_end |-> code_unit == 16'd0)
		else $error("end item carries a nonzero character");

	// Character positions stay below the character limit.
	a_index_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_end |-> char_index < 6'(MAX_CHARS))
		else $error("character position at or beyond the limit");

endmodule

bind utf8_to_ucs2_decoder_unit utd_checker #(.MAX_CHARS(MAX_CHARS)) u_utd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (char_ch.valid),
	.out_ready  (char_ch.ready),
	.code_unit  (char_ch.code_unit),
	.char_index (char_ch.char_index),
	.is_end     (char_ch.is_end)
);

// ----- sim/tb_utf8_to_ucs2_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 to UCS-2 decoder unit
// Directed byte sequences, a run up to the character limit and random strings
// go through the byte channel. A built-in decoder predicts every character and
// end item, and each item taken from the character channel is compared with
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb_utf8_to_ucs2_decoder_unit;
	import utd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// The block is built with its default limit, and the decoder below uses the
	// same value.
	localparam int unsigned CHAR_LIMIT = 60;

	// About this many bytes that the block actually decodes are sent at random.
	localparam int unsigned RANDOM_BYTES   = 1000;
	localparam int unsigned BURST_BYTES    = 200;
	localparam int unsigned DRAIN_CYCLES   = 12;

	logic clk;
	logic arst_n;

	utd_byte_if byte_ch ();
	utd_char_if char_ch ();

	utf8_to_ucs2_decoder_unit #(
		.MAX_CHARS (CHAR_LIMIT)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.char_ch (char_ch)
	);

	// Own copy of the decoder state: the code point being built (or the last
	// one held), the continuation bytes still due, the characters given out in
	// this string and whether the end item has already gone out.
	logic [15:0] held_point;
	logic [1:0]  cont_pending;
	logic [5:0]  char_count;
	logic        string_ended;

	// Characters and end items predicted but not yet seen on the output.
	utd_result_t expected_chars [$];

	int error_count;
	int bytes_decoded;

	// Chance in percent that a burst of idle cycles starts, on each side.
	int send_gap_pct;
	int stall_pct;

	// Clock with a 10 ns period.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A fixed time limit well above the slowest run: every byte waiting out the
	// longest gap and every result the longest stall still ends far sooner.
	initial begin
		#5_000_000;
		$display("utf8_to_ucs2_decoder_unit: mismatch");
		$finish;
	end

	// Queues one predicted result item.
	function automatic void expect_item(logic [15:0] code, logic [5:0] index, logic last);
		utd_result_t item;
		item.code_unit  = code;
		item.char_index = index;
		item.is_end     = last;
		expected_chars.push_back(item);
	endfunction

	// Predicts what one accepted byte does. Returns 1 when the byte took part
	// in decoding, 0 when the block ignores it (after the end of a string, or
	// a byte of 0xF8 and above).
	function automatic bit decode_byte(logic [7:0] b, logic fresh);
		if (fresh) begin
			held_point   = '0;
			cont_pending = '0;
			char_count   = '0;
			string_ended = 1'b0;
		end
		if (string_ended) begin
			return 1'b0;
		end

		// A zero byte ends the string, even in the middle of a sequence: the
		// partial character is dropped.
		if (b == END_BYTE) begin
			expect_item(16'h0000, char_count, 1'b1);
			string_ended = 1'b1;
			return 1'b1;
		end

		// Lead bytes load their payload bits and give nothing out.
		if (b >= LEAD2_MIN) begin
			if (b < LEAD3_MIN) begin
				cont_pending = 2'd1;
				held_point   = {8'h00, b & LEAD2_MASK};
			end else if (b < LEAD4_MIN) begin
				cont_pending = 2'd2;
				held_point   = {8'h00, b & LEAD3_MASK};
			end else if (b < INVAL_MIN) begin
				cont_pending = 2'd3;
				held_point   = {8'h00, b & LEAD4_MASK};
			end else begin
				return 1'b0;
			end
			return 1'b1;
		end

		if (b >= CONT_MIN) begin
			// A continuation byte shifts six bits in; the top bits of a four-byte
			// sequence fall off the 16-bit value. With nothing pending, the held
			// value is given out again unchanged.
			if (cont_pending != 2'd0) begin
				cont_pending = cont_pending - 2'd1;
				held_point   = {held_point[9:0], b[5:0]};
				if (cont_pending != 2'd0) begin
					return 1'b1;
				end
			end
		end else begin
			// ASCII replaces the held value but leaves the pending count alone.
			held_point = {8'h00, b};
		end

		expect_item(held_point, char_count, 1'b0);
		char_count = char_count + 6'd1;
		// On the character limit the end item follows in the same step.
		if (char_count >= 6'(CHAR_LIMIT)) begin
			expect_item(16'h0000, char_count, 1'b1);
			string_ended = 1'b1;
		end
		return 1'b1;
	endfunction

	// Sends one byte item and updates the prediction once it is accepted. Valid
	// stays high after acceptance unless a gap follows, so that back-to-back
	// items never drop and raise valid in the same time step.
	task automatic send_byte(input logic [7:0] b, input logic fresh);
		int gap;
		if ($urandom_range(0, 99) < send_gap_pct) begin
			gap = $urandom_range(1, 12);
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid      <= 1'b1;
		byte_ch.in_byte    <= b;
		byte_ch.new_string <= fresh;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		if (decode_byte(b, fresh)) begin
			bytes_decoded++;
		end
	endtask

	// Sends one random string. Most characters are well formed, of one to four
	// bytes with random payload. In ragged mode noise bytes are mixed in,
	// continuation bytes go missing and new_string sometimes rises mid-string.
	task automatic send_random_string(input bit ragged);
		int          n_chars;
		int          kind;
		int          seq_len;
		logic [20:0] point;
		logic [7:0]  seq [4];
		logic [7:0]  noise;
		logic        fresh;
		// Now and then a string is long enough to reach the character limit.
		n_chars = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 20);
		fresh   = 1'b1;
		for (int i = 0; i < n_chars; i++) begin
			if (ragged && $urandom_range(0, 11) == 0) begin
				noise = 8'($urandom_range(0, 255));
				send_byte(noise, fresh || ($urandom_range(0, 31) == 0));
				fresh = 1'b0;
			end
			point = 21'($urandom);
			kind  = $urandom_range(0, 5);
			case (kind)
				0, 1, 2: begin
					seq[0]  = {1'b0, point[6:0]};
					if (seq[0] == END_BYTE) begin
						seq[0] = 8'h7F;
					end
					seq_len = 1;
				end
				3: begin
					seq[0]  = LEAD2_MIN | {3'b000, point[10:6]};
					seq[1]  = CONT_MIN | {2'b00, point[5:0]};
					seq_len = 2;
				end
				4: begin
					seq[0]  = LEAD3_MIN | {4'h0, point[15:12]};
					seq[1]  = CONT_MIN | {2'b00, point[11:6]};
					seq[2]  = CONT_MIN | {2'b00, point[5:0]};
					seq_len = 3;
				end
				default: begin
					seq[0]  = LEAD4_MIN | {5'b00000, point[20:18]};
					seq[1]  = CONT_MIN | {2'b00, point[17:12]};
					seq[2]  = CONT_MIN | {2'b00, point[11:6]};
					seq[3]  = CONT_MIN | {2'b00, point[5:0]};
					seq_len = 4;
				end
			endcase
			for (int j = 0; j < seq_len; j++) begin
				if (!(ragged && j > 0 && $urandom_range(0, 15) == 0)) begin
					send_byte(seq[j], fresh);
					fresh = 1'b0;
				end
			end
		end
		// Most strings end with a zero byte; the others are cut off by the next
		// new_string. A few trailing bytes after the end must be ignored.
		if ($urandom_range(0, 9) != 0) begin
			send_byte(END_BYTE, fresh);
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					noise = 8'($urandom_range(1, 255));
					send_byte(noise, 1'b0);
				end
			end
		end
	endtask

	// Every class of byte and the corners of decoding below the character limit, in one short run.
	task automatic test_special_bytes();
		send_gap_pct = 20;
		stall_pct    = 20;
		send_byte(8'h41, 1'b1);    // plain ASCII
		send_byte(8'h7F, 1'b0);    // highest ASCII byte
		send_byte(8'hC3, 1'b0);    // two-byte character
		send_byte(8'hA9, 1'b0);
		send_byte(8'hEF, 1'b0);    // three-byte character with all bits set
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hF0, 1'b0);    // four-byte character, cut to 16 bits
		send_byte(8'h9F, 1'b0);
		send_byte(8'h98, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hF8, 1'b0);    // invalid lead bytes, ignored
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);    // stray continuation repeats the held value
		send_byte(8'hBF, 1'b0);
		send_byte(8'hE2, 1'b0);    // ASCII cuts into a pending sequence
		send_byte(8'h01, 1'b0);
		send_byte(8'hBF, 1'b0);    // still one continuation due afterward
		send_byte(8'h00, 1'b0);    // zero byte drops the partial character
		send_byte(8'h41, 1'b0);    // after the end: ignored
		send_byte(8'h00, 1'b1);    // empty string
		send_byte(8'hDF, 1'b1);    // largest two-byte value
		send_byte(8'hBF, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	// A string of exactly the limit: the last character and the end item come
	// from one byte, here with the receiver stalling hard so the two queue up.
	task automatic test_char_limit();
		logic [7:0] ch;
		send_gap_pct = 0;
		stall_pct    = 40;
		for (int i = 0; i < CHAR_LIMIT; i++) begin
			ch = 8'($urandom_range(1, 127));
			send_byte(ch, i == 0);
		end
		send_byte(8'h41, 1'b0);    // past the limit: ignored
		send_byte(8'h00, 1'b0);
	endtask

	// Random strings, with idling of both sides chosen anew per string so some
	// strings run with no gaps at all.
	task automatic test_random_strings();
		int start;
		start = bytes_decoded;
		while (bytes_decoded - start < RANDOM_BYTES) begin
			case ($urandom_range(0, 2))
				0: send_gap_pct = 0;
				1: send_gap_pct = 10;
				default: send_gap_pct = 30;
			endcase
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 10;
				default: stall_pct = 30;
			endcase
			send_random_string($urandom_range(0, 3) == 0);
		end
	endtask

	// The closing part: full rate on both sides with no idling.
	task automatic test_full_rate();
		int start;
		send_gap_pct = 0;
		stall_pct    = 0;
		start        = bytes_decoded;
		while (bytes_decoded - start < BURST_BYTES) begin
			send_random_string($urandom_range(0, 4) == 0);
		end
	endtask

	// Receiver side: ready drops in bursts of random length. Exactly one
	// nonblocking assignment to ready happens per clock edge.
	initial begin : drive_ready
		int stall_left;
		stall_left    = 0;
		char_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				char_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				stall_left    = $urandom_range(0, 11);
				char_ch.ready <= 1'b0;
			end else begin
				char_ch.ready <= 1'b1;
			end
		end
	end

	// Every item taken from the character channel is compared with the oldest
	// prediction. Outputs are read right after the edge, so the values seen are
	// the ones that held at the edge.
	always @(posedge clk) begin : check_chars
		utd_result_t want;
		if (arst_n && char_ch.valid && char_ch.ready) begin
			if (expected_chars.size() == 0) begin
				$error("item with no prediction: code_unit %h char_index %0d is_end %0b",
					char_ch.code_unit, char_ch.char_index, char_ch.is_end);
				error_count++;
			end else begin
				want = expected_chars.pop_front();
				if (char_ch.code_unit !== want.code_unit) begin
					$error("code_unit: expected %h, actual %h", want.code_unit,
						char_ch.code_unit);
					error_count++;
				end
				if (char_ch.char_index !== want.char_index) begin
					$error("char_index: expected %0d, actual %0d", want.char_index,
						char_ch.char_index);
					error_count++;
				end
				if (char_ch.is_end !== want.is_end) begin
					$error("is_end: expected %0b, actual %0b", want.is_end, char_ch.is_end);
					error_count++;
				end
			end
		end
	end

	// Main sequence: reset, the tests in turn, then drain and report.
	initial begin
		error_count        = 0;
		bytes_decoded      = 0;
		send_gap_pct       = 0;
		stall_pct          = 0;
		held_point         = '0;
		cont_pending       = '0;
		char_count         = '0;
		string_ended       = 1'b0;
		byte_ch.valid      = 1'b0;
		byte_ch.in_byte    = '0;
		byte_ch.new_string = 1'b0;
		arst_n             = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_bytes();
		test_char_limit();
		test_random_strings();
		test_full_rate();

		// Lowered in the step of the last acceptance, so valid sees one update.
		byte_ch.valid <= 1'b0;

		// Wait for every predicted item, then for a drain period to catch any
		// extra item the block might still send.
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("utf8_to_ucs2_decoder_unit: match");
		end else begin
			$display("utf8_to_ucs2_decoder_unit: mismatch");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/utd_pkg.sv
rtl/utd_byte_if.sv
rtl/utd_char_if.sv
rtl/utd_decode.sv
rtl/utf8_to_ucs2_decoder_unit.sv
rtl/utd_checker.sv
sim/tb_utf8_to_ucs2_decoder_unit.sv
